// ===== rtl/core/pcbb_pkg.sv =====
// shared types, constants and helpers for the prefix-compressed block builder
// no dependencies; imported by every module of the block
`default_nettype none

package pcbb_pkg;

    localparam int MAX_KEY_LEN  = 32;
    localparam int MAX_RESTARTS = 63;
    localparam int WORD_BYTES   = 4;
    localparam int QDEPTH       = 4;

    localparam int KLEN_W  = 6;
    localparam int KADDR_W = $clog2(MAX_KEY_LEN);
    localparam int RCNT_W  = 7;
    localparam int RADDR_W = $clog2(MAX_RESTARTS + 1);
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [2:0] CMD_BEGIN  = 3'd0;
    localparam logic [2:0] CMD_KEY    = 3'd1;
    localparam logic [2:0] CMD_VALUE  = 3'd2;
    localparam logic [2:0] CMD_FINISH = 3'd3;
    localparam logic [2:0] CMD_RESET  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    typedef enum logic [1:0] {
        JOB_STATUS = 2'd0,
        JOB_VALUE  = 2'd1,
        JOB_EOK    = 2'd2,
        JOB_FINISH = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         code;
        logic [7:0]         dbyte;
        logic [KLEN_W-1:0]  sh;
        logic [KLEN_W-1:0]  len;
        logic [15:0]        vlen;
        logic [RCNT_W-1:0]  rc;
        logic [31:0]        est;
    } t_job;

    typedef struct packed {
        logic [31:0] data;
        logic        is_word;
        logic [1:0]  status;
        logic [31:0] est;
        logic        last;
    } t_result;

    typedef struct packed {
        logic               key_en;
        logic [KADDR_W-1:0] key_addr;
        logic               off_en;
        logic [RADDR_W-1:0] off_addr;
    } t_rd_req;

    typedef struct packed {
        logic [7:0]  key_data;
        logic [31:0] off_data;
    } t_rd_rsp;

    function automatic logic [1:0] f_vbytes(input logic [15:0] v);
        logic [1:0] n;
        if (v < 16'd128) n = 2'd1;
        else if (v < 16'd16384) n = 2'd2;
        else n = 2'd3;
        return n;
    endfunction

    function automatic logic [31:0] f_est(input logic [31:0] bc, input logic [RCNT_W-1:0] rc);
        return bc + 32'({rc, 2'b00}) + 32'(WORD_BYTES);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcbb_queue.sv =====
// short job queue between the front and back parts
// depends on pcbb_pkg for the job type and depth
`default_nettype none

module pcbb_queue
    import pcbb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

`default_nettype wire

// ===== rtl/core/pcbb_front.sv =====
// front part: accepts commands, tracks entry state, key store and restart offsets
// depends on pcbb_pkg; pushes jobs into pcbb_queue
`default_nettype none

module pcbb_front
    import pcbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [5:0]  i_klen,
    input  wire logic [15:0] i_vlen,
    input  wire logic [7:0]  i_byte,
    output logic             o_push,
    output t_job             o_job,
    input  wire logic        i_q_full,
    input  wire logic        i_done,
    input  wire t_rd_req     i_rd_req,
    output t_rd_rsp          o_rd_rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state             r_state;
    logic [2:0]         r_cmd;
    logic [5:0]         r_klen;
    logic [15:0]        r_vlen;
    logic [7:0]         r_byte;
    logic [7:0]         r_interval;
    logic [KLEN_W-1:0]  r_prev_len, n_prev_len;
    logic [KLEN_W-1:0]  r_cur_len,  n_cur_len;
    logic [KLEN_W-1:0]  r_kpos,     n_kpos;
    logic [KLEN_W-1:0]  r_shared,   n_shared;
    logic               r_match,    n_match;
    logic [7:0]         r_ec,       n_ec;
    logic [15:0]        r_pvl,      n_pvl;
    logic [RCNT_W-1:0]  r_rc,       n_rc;
    logic [31:0]        r_bc,       n_bc;
    logic               r_fin,      n_fin;
    logic [2:0]         r_busy;

    logic [7:0]  r_key_mem [MAX_KEY_LEN];
    logic [31:0] r_off_mem [MAX_RESTARTS];
    logic [7:0]  r_kdata;
    logic [7:0]  r_kdata_b;
    logic [31:0] r_odata_b;

    logic       accept, go, key_we, off_we, push, busy_job;
    t_job       job;
    logic       in_key, in_val, idle, restart, hit;
    logic [KLEN_W-1:0] v_sh, v_len, v_kpos;
    logic [RCNT_W-1:0] v_rc;
    logic [7:0]        v_ec;

    assign accept = (r_state == S_IDLE) && i_valid;
    assign o_ready = (r_state == S_IDLE);
    assign go = (r_state == S_EXEC) && !i_q_full &&
                !(((r_cmd == CMD_BEGIN) || (r_cmd == CMD_KEY)) && (r_busy != '0));

    always_comb begin
        n_prev_len = r_prev_len;
        n_cur_len  = r_cur_len;
        n_kpos     = r_kpos;
        n_shared   = r_shared;
        n_match    = r_match;
        n_ec       = r_ec;
        n_pvl      = r_pvl;
        n_rc       = r_rc;
        n_bc       = r_bc;
        n_fin      = r_fin;
        key_we     = 1'b0;
        off_we     = 1'b0;
        push       = 1'b0;
        job        = '0;
        job.kind   = JOB_STATUS;
        job.code   = ST_ORDER;
        job.est    = f_est(r_bc, r_rc);
        in_key     = r_kpos < r_cur_len;
        in_val     = !in_key && (r_pvl != '0);
        idle       = !in_key && !in_val;
        restart    = r_ec >= r_interval;
        hit        = 1'b0;
        v_sh       = '0;
        v_len      = '0;
        v_kpos     = '0;
        v_rc       = r_rc;
        v_ec       = r_ec;
        if (r_cmd == CMD_RESET) begin
            n_prev_len = '0;
            n_cur_len  = '0;
            n_kpos     = '0;
            n_shared   = '0;
            n_match    = 1'b1;
            n_ec       = '0;
            n_pvl      = '0;
            n_rc       = RCNT_W'(1);
            n_bc       = '0;
            n_fin      = 1'b0;
        end else if (r_fin || (r_cmd > CMD_RESET)) begin
            push = 1'b1;
        end else begin
            case (r_cmd)
                CMD_BEGIN: begin
                    push = 1'b1;
                    if (!idle || (r_klen > 6'(MAX_KEY_LEN))) begin
                        job.code = ST_ORDER;
                    end else if (restart && (r_rc >= RCNT_W'(MAX_RESTARTS))) begin
                        job.code = ST_FULL;
                    end else begin
                        push = 1'b0;
                        if (restart) begin
                            off_we = 1'b1;
                            v_rc   = r_rc + 1'b1;
                            v_ec   = '0;
                        end
                        n_cur_len = r_klen;
                        n_kpos    = '0;
                        n_shared  = '0;
                        n_match   = !restart;
                        n_pvl     = r_vlen;
                        if (r_klen == '0) begin
                            push       = 1'b1;
                            n_bc       = r_bc + 32'd2 + 32'(f_vbytes(r_vlen));
                            n_prev_len = '0;
                            v_ec       = v_ec + 1'b1;
                            job.kind   = JOB_EOK;
                            job.code   = ST_OK;
                            job.vlen   = r_vlen;
                            job.rc     = v_rc;
                            job.est    = f_est(n_bc, v_rc);
                        end
                        n_rc = v_rc;
                        n_ec = v_ec;
                    end
                end
                CMD_KEY: begin
                    if (!in_key) begin
                        push = 1'b1;
                    end else begin
                        hit      = r_match && (r_kpos < r_prev_len) && (r_kdata == r_byte);
                        v_sh     = hit ? r_shared + 1'b1 : r_shared;
                        n_match  = hit;
                        n_shared = v_sh;
                        key_we   = 1'b1;
                        v_kpos   = r_kpos + 1'b1;
                        n_kpos   = v_kpos;
                        if (v_kpos >= r_cur_len) begin
                            v_len      = r_cur_len;
                            if (v_sh > v_len) v_sh = v_len;
                            push       = 1'b1;
                            n_bc       = r_bc + 32'd2 + 32'(f_vbytes(r_pvl))
                                         + 32'(v_len - v_sh);
                            n_prev_len = v_len;
                            n_ec       = r_ec + 1'b1;
                            job.kind   = JOB_EOK;
                            job.code   = ST_OK;
                            job.sh     = v_sh;
                            job.len    = v_len;
                            job.vlen   = r_pvl;
                            job.est    = f_est(n_bc, r_rc);
                        end
                    end
                end
                CMD_VALUE: begin
                    push = 1'b1;
                    if (in_val) begin
                        n_bc      = r_bc + 32'd1;
                        n_pvl     = r_pvl - 1'b1;
                        job.kind  = JOB_VALUE;
                        job.code  = ST_OK;
                        job.dbyte = r_byte;
                        job.est   = f_est(n_bc, r_rc);
                    end
                end
                CMD_FINISH: begin
                    push = 1'b1;
                    if (idle) begin
                        n_bc     = r_bc + 32'({r_rc + 1'b1, 2'b00});
                        n_fin    = 1'b1;
                        job.kind = JOB_FINISH;
                        job.code = ST_OK;
                        job.rc   = r_rc;
                        job.est  = f_est(n_bc, r_rc);
                    end
                end
                default: begin
                    push = 1'b1;
                end
            endcase
        end
    end

    assign o_push   = go && push;
    assign o_job    = job;
    assign busy_job = (job.kind == JOB_EOK) || (job.kind == JOB_FINISH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_interval <= 8'd16;
            r_prev_len <= '0;
            r_cur_len  <= '0;
            r_kpos     <= '0;
            r_shared   <= '0;
            r_match    <= 1'b1;
            r_ec       <= '0;
            r_pvl      <= '0;
            r_rc       <= RCNT_W'(1);
            r_bc       <= '0;
            r_fin      <= 1'b0;
            r_busy     <= '0;
        end else begin
            if (i_cfg_wr_en) r_interval <= i_cfg_wr_data;
            r_busy <= r_busy + 3'(o_push && busy_job) - 3'(i_done);
            case (r_state)
                S_IDLE: if (accept) r_state <= S_EXEC;
                S_EXEC: begin
                    if (go) begin
                        r_state    <= S_IDLE;
                        r_prev_len <= n_prev_len;
                        r_cur_len  <= n_cur_len;
                        r_kpos     <= n_kpos;
                        r_shared   <= n_shared;
                        r_match    <= n_match;
                        r_ec       <= n_ec;
                        r_pvl      <= n_pvl;
                        r_rc       <= n_rc;
                        r_bc       <= n_bc;
                        r_fin      <= n_fin;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_klen  <= i_klen;
            r_vlen  <= i_vlen;
            r_byte  <= i_byte;
            r_kdata <= r_key_mem[r_kpos[KADDR_W-1:0]];
        end
        if (go && key_we) r_key_mem[r_kpos[KADDR_W-1:0]] <= r_byte;
        if (go && off_we) r_off_mem[r_rc[RADDR_W-1:0]] <= r_bc;
        if (i_rd_req.key_en) r_kdata_b <= r_key_mem[i_rd_req.key_addr];
        if (i_rd_req.off_en) r_odata_b <= r_off_mem[i_rd_req.off_addr];
    end

    assign o_rd_rsp.key_data = r_kdata_b;
    assign o_rd_rsp.off_data = r_odata_b;

endmodule

`default_nettype wire

// ===== rtl/core/pcbb_back.sv =====
// back part: expands queued jobs into result transactions through an output register
// depends on pcbb_pkg; reads key store and restart offsets through the front
`default_nettype none

module pcbb_back
    import pcbb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_job    i_job,
    input  wire logic    i_q_empty,
    output logic         o_pop,
    output logic         o_done,
    output t_rd_req      o_rd_req,
    input  wire t_rd_rsp i_rd_rsp,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_ONE  = 8'b00000010,
        S_HDR  = 8'b00000100,
        S_KRD  = 8'b00001000,
        S_KOUT = 8'b00010000,
        S_WRD  = 8'b00100000,
        S_WOUT = 8'b01000000,
        S_CNT  = 8'b10000000
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [2:0]        r_hidx;
    logic [KLEN_W-1:0] r_kidx;
    logic [RCNT_W-1:0] r_widx;
    t_result           r_out;
    logic              r_out_valid;

    logic       can_load;
    logic       load;
    logic [7:0] hdr;
    logic [2:0] hdr_last;
    logic       no_key;

    assign can_load = !r_out_valid || i_ready;
    assign load     = can_load && ((r_state == S_ONE) || (r_state == S_HDR) ||
                                   (r_state == S_KOUT) || (r_state == S_WOUT) ||
                                   (r_state == S_CNT));
    assign no_key   = (r_job.len == r_job.sh);
    assign hdr_last = 3'd1 + 3'(f_vbytes(r_job.vlen));

    always_comb begin
        case (r_hidx)
            3'd0:    hdr = 8'(r_job.sh);
            3'd1:    hdr = 8'(r_job.len - r_job.sh);
            3'd2:    hdr = (r_job.vlen < 16'd128) ? {1'b0, r_job.vlen[6:0]}
                                                  : {1'b1, r_job.vlen[6:0]};
            3'd3:    hdr = (r_job.vlen < 16'd16384) ? {1'b0, r_job.vlen[13:7]}
                                                    : {1'b1, r_job.vlen[13:7]};
            default: hdr = {6'd0, r_job.vlen[15:14]};
        endcase
    end

    assign o_pop             = (r_state == S_IDLE) && !i_q_empty;
    assign o_rd_req.key_en   = (r_state == S_KRD);
    assign o_rd_req.key_addr = r_kidx[KADDR_W-1:0];
    assign o_rd_req.off_en   = (r_state == S_WRD);
    assign o_rd_req.off_addr = r_widx[RADDR_W-1:0];

    always_comb begin
        o_done = 1'b0;
        if (can_load) begin
            case (r_state)
                S_HDR:   o_done = (r_hidx == hdr_last) && no_key;
                S_KOUT:  o_done = (r_kidx + 1'b1 == r_job.len);
                S_CNT:   o_done = 1'b1;
                default: o_done = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= load || (r_out_valid && !i_ready);
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job  <= i_job;
                        r_hidx <= '0;
                        r_kidx <= i_job.sh;
                        r_widx <= '0;
                        case (i_job.kind)
                            JOB_EOK:    r_state <= S_HDR;
                            JOB_FINISH: r_state <= S_WOUT;
                            default:    r_state <= S_ONE;
                        endcase
                    end
                end
                S_ONE: begin
                    if (can_load) begin
                        r_out.data    <= {24'd0, r_job.dbyte};
                        r_out.is_word <= 1'b0;
                        r_out.status  <= (r_job.kind == JOB_STATUS) ? r_job.code : ST_OK;
                        r_out.est     <= r_job.est;
                        r_out.last    <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_HDR: begin
                    if (can_load) begin
                        r_out.data    <= {24'd0, hdr};
                        r_out.is_word <= 1'b0;
                        r_out.status  <= ST_OK;
                        r_out.est     <= r_job.est;
                        r_out.last    <= (r_hidx == hdr_last) && no_key;
                        r_hidx        <= r_hidx + 1'b1;
                        if (r_hidx == hdr_last) r_state <= no_key ? S_IDLE : S_KRD;
                    end
                end
                S_KRD: r_state <= S_KOUT;
                S_KOUT: begin
                    if (can_load) begin
                        r_out.data    <= {24'd0, i_rd_rsp.key_data};
                        r_out.is_word <= 1'b0;
                        r_out.status  <= ST_OK;
                        r_out.est     <= r_job.est;
                        r_out.last    <= (r_kidx + 1'b1 == r_job.len);
                        r_kidx        <= r_kidx + 1'b1;
                        r_state       <= (r_kidx + 1'b1 == r_job.len) ? S_IDLE : S_KRD;
                    end
                end
                S_WRD: r_state <= S_WOUT;
                S_WOUT: begin
                    if (can_load) begin
                        // offset zero is never stored
                        r_out.data    <= (r_widx == '0) ? 32'd0 : i_rd_rsp.off_data;
                        r_out.is_word <= 1'b1;
                        r_out.status  <= ST_OK;
                        r_out.est     <= r_job.est;
                        r_out.last    <= 1'b0;
                        r_widx        <= r_widx + 1'b1;
                        r_state       <= (r_widx + 1'b1 == r_job.rc) ? S_CNT : S_WRD;
                    end
                end
                S_CNT: begin
                    if (can_load) begin
                        r_out.data    <= 32'(r_job.rc);
                        r_out.is_word <= 1'b1;
                        r_out.status  <= ST_OK;
                        r_out.est     <= r_job.est;
                        r_out.last    <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KOUT) |-> (r_kidx < r_job.len))
        else $error("key index past key length");

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WOUT) |-> (r_widx < r_job.rc))
        else $error("restart word index past restart count");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |-> r_out.last)
        else $error("status result not marked last");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_out_valid && r_out.last))
        else $error("job completion without final result");

endmodule

`default_nettype wire

// ===== rtl/core/prefix_compressed_block_builder_core.sv =====
// top level of the prefix-compressed block builder
// depends on pcbb_pkg, pcbb_front, pcbb_queue and pcbb_back
// order: the front registers an input transaction, then executes it and pushes a job into the
//   queue; the back then loads the job, then its output register, from which a result is taken
// throughput: a command is taken only once the previous one has executed, later while the queue
//   is full or while a begin or key byte waits for a pending end-of-key or finish expansion;
//   header bytes leave at one per cycle while the output is not stalled; a value or status
//   result returns to idle; key bytes and restart words each wait on a registered memory read
// reset: i_rst_n synchronous active low; key store contents stay undefined until written
`default_nettype none

module prefix_compressed_block_builder_core
    import pcbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // restart interval register
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // command stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // key_length[5:0], value_length[21:6], data_byte[29:22]
    input  wire logic [2:0]  i_s_tuser,   // command[2:0]
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // out_data[31:0], size_estimate[63:32]
    output logic [2:0]       o_m_tuser,   // out_is_word[0], status[2:1]
    output logic             o_m_tlast
);

    // jobs flow front -> queue -> back
    t_job    front_job;
    t_job    q_job;
    logic    front_push;
    logic    q_full;
    logic    q_empty;
    logic    back_pop;
    logic    back_done;
    t_rd_req rd_req;
    t_rd_rsp rd_rsp;
    t_result res;

    pcbb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_cmd         (i_s_tuser),
        .i_klen        (i_s_tdata[5:0]),
        .i_vlen        (i_s_tdata[21:6]),
        .i_byte        (i_s_tdata[29:22]),
        .o_push        (front_push),
        .o_job         (front_job),
        .i_q_full      (q_full),
        .i_done        (back_done),
        .i_rd_req      (rd_req),
        .o_rd_rsp      (rd_rsp)
    );

    pcbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    pcbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_job),
        .i_q_empty (q_empty),
        .o_pop     (back_pop),
        .o_done    (back_done),
        .o_rd_req  (rd_req),
        .i_rd_rsp  (rd_rsp),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (res)
    );

    // pack the result transaction
    assign o_m_tdata = {res.est, res.data};
    assign o_m_tuser = {res.status, res.is_word};
    assign o_m_tlast = res.last;

endmodule

`default_nettype wire
